### hdl/futr_pkg.sv
// Shared types and constants for the first unique symbol tracker.
package futr_pkg;

	// Width of the symbol field on the ports.
	localparam int SYM_W = 8;
	// Bits of a symbol that are tracked; wider input codes wrap to these bits.
	localparam int SYMBOL_BITS = 8;
	// Number of distinct symbols, which is also the number of cells.
	localparam int ALPHA_SIZE = 1 << SYMBOL_BITS;
	// Queue fill counter width; it must be able to hold the alphabet size.
	localparam int FILL_W = SYMBOL_BITS + 1;

	// Contents of one queue cell.
	typedef struct packed {
		logic                   occ;
		logic                   many;
		logic [SYMBOL_BITS-1:0] sym;
	} cell_t;

	// Control that is broadcast to every cell.
	typedef struct packed {
		logic                   accept;
		logic                   clear;
		logic                   mark;
		logic                   shift;
		logic [SYMBOL_BITS-1:0] symbol;
	} cell_ctrl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

### hdl/futr_cell.sv
// One cell of the arrival-order chain: holds one queued symbol and its repeat flag.
module futr_cell import futr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       ins,
	input  cell_t      nbr,
	output cell_t      cur,
	output logic       hit
);

	logic                   occ_q;
	logic                   many_q;
	logic [SYMBOL_BITS-1:0] sym_q;

	// The cell matches when it holds the symbol of the current transfer.
	assign hit = occ_q && (sym_q == ctrl.symbol);

	// Occupancy: taken from the neighbor on a shift, set on insert, dropped on clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			priority if (ctrl.shift) begin
				occ_q <= nbr.occ;
			end else if (ctrl.accept && ins) begin
				occ_q <= 1'b1;
			end else if (ctrl.accept && ctrl.clear) begin
				occ_q <= 1'b0;
			end
		end
	end

	// Symbol and repeat flag; a repeat of the held symbol marks the cell.
	always_ff @(posedge clk) begin
		priority if (ctrl.shift) begin
			many_q <= nbr.many;
			sym_q  <= nbr.sym;
		end else if (ctrl.accept && ins) begin
			many_q <= 1'b0;
			sym_q  <= ctrl.symbol;
		end else if (ctrl.accept && ctrl.mark && hit) begin
			many_q <= 1'b1;
		end
	end

	assign cur.occ  = occ_q;
	assign cur.many = many_q;
	assign cur.sym  = sym_q;

endmodule

### hdl/first_unique_symbol_tracker_unit.sv
// Top level of the first unique symbol tracker: cell ring and sequencer.
// After every symbol transfer the block returns the earliest symbol of the current
// stream that has arrived exactly once (found = 1), or found = 0 and a zero symbol
// when there is none. Every distinct symbol of the stream is kept in a ring of
// cells, one cell per alphabet symbol, with cell 0 at the head. Live symbols sit
// in arrival order from the head, free cells follow, and symbols that have been
// dropped as repeated sit at the end of the ring. A symbol counts as seen when any
// occupied cell holds it. A new symbol is written into the first free cell in the
// cycle it is transferred in, and a repeat marks the matching cell. Marked cells at
// the head are then dropped by rotating the whole ring one cell toward the head per
// cycle, which moves the dropped entry to the end of the ring. Each symbol is
// dropped at most once per stream. A start_of_stream item clears all state in
// its own transfer cycle, so no clearing pass is needed after reset. The input is
// stalled while an item is being worked on, and a finished result waits in an
// output register until it is taken.
module first_unique_symbol_tracker_unit import futr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [SYM_W-1:0] symbol,
	input  logic             start_of_stream,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output logic [SYM_W-1:0] unique_symbol
);

	state_t                 state_q;
	logic                   accept;
	logic                   pop;
	logic                   load_out;
	logic [SYMBOL_BITS-1:0] sym_in;
	logic [ALPHA_SIZE-1:0]  hit_vec;
	logic                   seen_eff;
	logic [FILL_W-1:0]      fill_q;
	logic [FILL_W-1:0]      fill_eff;
	logic                   ins_en;
	logic [ALPHA_SIZE-1:0]  ins_vec;
	cell_ctrl_t             ctrl;
	cell_t                  cells [ALPHA_SIZE];
	logic                   out_valid_q;
	logic                   found_q;
	logic [SYM_W-1:0]       uniq_q;

	// Input transfer and the symbol reduced to the tracked width.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign sym_in   = SYMBOL_BITS'(symbol);

	// Start of stream makes the block look empty before this symbol is taken.
	assign seen_eff = start_of_stream ? 1'b0 : (|hit_vec);
	assign fill_eff = start_of_stream ? '0 : fill_q;
	assign ins_en   = !seen_eff;

	// Head drop while draining, and result load once the head is settled.
	assign pop      = (state_q == ST_DRAIN) && (fill_q != '0) && cells[0].many;
	assign load_out = (state_q == ST_DRAIN) && !pop && (!out_valid_q || !out_stall);

	// Broadcast control to the ring; a cell only marks when it holds the symbol.
	assign ctrl.accept = accept;
	assign ctrl.clear  = start_of_stream;
	assign ctrl.mark   = !start_of_stream;
	assign ctrl.shift  = pop;
	assign ctrl.symbol = sym_in;

	// Number of live cells; they always form a prefix of the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			priority if (accept) begin
				fill_q <= fill_eff + FILL_W'(ins_en);
			end else if (pop) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Ring of cells; each takes its upper neighbor on a shift, the last takes the head.
	for (genvar i = 0; i < ALPHA_SIZE; i++) begin : g_cell
		cell_t nbr;

		assign ins_vec[i] = ins_en && (fill_eff == FILL_W'(i));

		if (i == ALPHA_SIZE - 1) begin : g_last
			assign nbr = cells[0];
		end else begin : g_mid
			assign nbr = cells[i+1];
		end

		futr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.ins    (ins_vec[i]),
			.nbr    (nbr),
			.cur    (cells[i]),
			.hit    (hit_vec[i])
		);
	end

	// Sequencer: take an item, then drain repeated heads and hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= (fill_q != '0);
			uniq_q  <= (fill_q != '0) ? SYM_W'(cells[0].sym) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign unique_symbol = uniq_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the first unique symbol tracker unit.
module tb_top;
	import futr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Occurrence classes of a symbol within the current stream.
	typedef enum logic [1:0] {
		SEEN_NONE = 2'd0,
		SEEN_ONCE = 2'd1,
		SEEN_MANY = 2'd2
	} seen_t;

	// One symbol transfer with the idle cycles that precede it.
	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             sos;
		int unsigned      gap;
	} symbol_item_t;

	// One expected answer of the block.
	typedef struct {
		logic             found;
		logic [SYM_W-1:0] sym;
	} answer_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 2 * ALPHA_SIZE + 40;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [SYM_W-1:0] symbol;
	logic             start_of_stream;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	logic [SYM_W-1:0] unique_symbol;

	symbol_item_t symbols_to_send[$];
	answer_t      answers_due[$];
	seen_t        sym_tally[ALPHA_SIZE];
	logic [SYMBOL_BITS-1:0] arrival_order[$];

	int unsigned items_built;
	int unsigned streams_built;
	int unsigned symbols_sent;
	int unsigned answers_seen;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned gap_left;
	int unsigned stall_left;

	first_unique_symbol_tracker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol(symbol),
		.start_of_stream(start_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.unique_symbol(unique_symbol)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Track one symbol of the stream and queue the answer it must produce.
	task automatic track_symbol(input logic [SYM_W-1:0] sym, input logic sos);
		logic [SYMBOL_BITS-1:0] code;
		answer_t ans;
		code = sym[SYMBOL_BITS-1:0];
		if (sos) begin
			foreach (sym_tally[i]) sym_tally[i] = SEEN_NONE;
			arrival_order.delete();
		end
		if (sym_tally[code] == SEEN_NONE) begin
			sym_tally[code] = SEEN_ONCE;
			arrival_order.insert(arrival_order.size(), code);
		end else begin
			sym_tally[code] = SEEN_MANY;
		end
		// Drop repeated symbols from the front of the arrival order.
		while (arrival_order.size() != 0 && sym_tally[arrival_order[0]] == SEEN_MANY)
			void'(arrival_order.pop_front());
		ans.found = (arrival_order.size() != 0);
		ans.sym = '0;
		if (ans.found)
			ans.sym = SYM_W'(arrival_order[0]);
		answers_due.insert(answers_due.size(), ans);
	endtask

	// Queue one symbol; every fourth block of items runs back to back.
	task automatic add_symbol(input logic [SYM_W-1:0] sym, input logic sos);
		symbol_item_t it;
		it.sym = sym;
		it.sos = sos;
		if ((items_built / 60) % 4 == 3)
			it.gap = 0;
		else
			it.gap = $urandom_range(0, 11);
		symbols_to_send.insert(symbols_to_send.size(), it);
		items_built++;
		if (sos)
			streams_built++;
	endtask

	// Driver: presents queued symbols and records each accepted transfer.
	always @(posedge clk or negedge arst_n) begin
		symbol_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			symbol <= '0;
			start_of_stream <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_symbol(symbol, start_of_stream);
				symbols_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (symbols_to_send.size() != 0) begin
					it = symbols_to_send.pop_front();
					in_valid <= 1'b1;
					symbol <= it.sym;
					start_of_stream <= it.sos;
					gap_left <= (symbols_to_send.size() != 0) ? symbols_to_send[0].gap : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		answer_t ans;
		int unsigned hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result: expected none, actual found=%0b symbol=%0h",
						$time, found, unique_symbol);
				end else begin
					ans = answers_due.pop_front();
					if (found !== ans.found) begin
						error_count++;
						$display("%0t: found mismatch: expected %0b, actual %0b",
							$time, ans.found, found);
					end
					if (unique_symbol !== ans.sym) begin
						error_count++;
						$display("%0t: unique_symbol mismatch: expected %0h, actual %0h",
							$time, ans.sym, unique_symbol);
					end
				end
				// Every third block of results is taken without stalls.
				hold = ((answers_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
				stall_left <= hold;
				out_stall <= (hold != 0);
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else begin
				stall_left <= 0;
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, answers_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned kind;
		int unsigned len;
		int unsigned span;
		int unsigned step;
		logic [SYM_W-1:0] base;
		arst_n = 1'b0;
		foreach (sym_tally[i]) sym_tally[i] = SEEN_NONE;

		// Directed: extreme codes, repeats, restarts.
		add_symbol(8'h00, 1'b1);
		add_symbol(8'hFF, 1'b0);
		add_symbol(8'h00, 1'b0);
		add_symbol(8'h00, 1'b0);
		add_symbol(8'hFF, 1'b0);
		add_symbol(8'hFF, 1'b0);
		add_symbol(8'h80, 1'b0);
		add_symbol(8'h01, 1'b0);
		add_symbol(8'h7F, 1'b0);
		add_symbol(8'hFE, 1'b0);
		add_symbol(8'h55, 1'b0);
		add_symbol(8'hAA, 1'b0);
		add_symbol(8'h80, 1'b0);
		add_symbol(8'h01, 1'b0);
		add_symbol(8'h7F, 1'b0);
		add_symbol(8'hFE, 1'b0);
		add_symbol(8'hAA, 1'b1);
		add_symbol(8'hAA, 1'b0);
		add_symbol(8'hAA, 1'b1);
		add_symbol(8'h00, 1'b1);

		// Random streams, mostly well formed with a narrow alphabet.
		while (items_built < 430) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				len = $urandom_range(1, 40);
				span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
				base = SYM_W'($urandom);
				for (int i = 0; i < len; i++)
					add_symbol(base + SYM_W'($urandom_range(0, span - 1)), i == 0);
			end else if (kind == 7) begin
				// Many distinct symbols, then repeats in arrival order for long drops.
				len = $urandom_range(20, 60);
				step = ($urandom_range(0, 127) << 1) | 1;
				base = SYM_W'($urandom);
				for (int i = 0; i < len; i++)
					add_symbol(base + SYM_W'(i * step), i == 0);
				for (int i = 0; i < len; i++)
					if ($urandom_range(0, 3) != 0)
						add_symbol(base + SYM_W'(i * step), 1'b0);
			end else begin
				// Noise: full range symbols with occasional stream restarts.
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					add_symbol(SYM_W'($urandom), $urandom_range(0, 7) == 0);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every symbol is sent and every answer has arrived.
		while (symbols_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (answers_due.size() != 0)
			error_count++;

		$display("Sent %0d symbols in %0d streams and checked %0d results.",
			symbols_sent, streams_built, answers_seen);
		$display("Streams mixed narrow alphabets, long drop runs, noise and random idling.");
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d errors found.", error_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
